[rtl/csr_spmv_accumulate_defines.svh]
// assertion macros for the csr sparse matrix-vector accumulator
`ifndef CSR_SPMV_ACCUMULATE_DEFINES_SVH
`define CSR_SPMV_ACCUMULATE_DEFINES_SVH

`ifndef SYNTHESIS

`define CSR_SPMV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define CSR_SPMV_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CSR_SPMV_ASSERT(lbl, clk, rst_n, prop, msg)

`define CSR_SPMV_ASSERT_NORST(lbl, clk, prop, msg)

`endif

`endif

[rtl/csr_spmv_pkg.sv]
package csr_spmv_pkg;

    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int ACC_W = 48;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_APPLY = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MUL,
        ST_ACC,
        ST_READ
    } t_state;

endpackage

[rtl/csr_spmv_ram.sv]
module csr_spmv_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/csr_spmv_mac.sv]
module csr_spmv_mac (
    input  logic                                     i_clk,
    input  logic                                     i_mul_en,
    input  logic signed [csr_spmv_pkg::VAL_W-1:0]    i_value,
    input  logic signed [csr_spmv_pkg::VAL_W-1:0]    i_vec,
    input  logic signed [csr_spmv_pkg::ACC_W-1:0]    i_acc,
    output logic signed [csr_spmv_pkg::ACC_W-1:0]    o_sum,
    output logic                                     o_ovf
);

    import csr_spmv_pkg::*;

    logic signed [2*VAL_W-1:0] w_prod;
    logic signed [2*VAL_W-1:0] r_prod;
    logic signed [ACC_W:0]     w_sum;

    assign w_prod = i_value * i_vec;

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= w_prod;
        end
    end

    // round half up: add bit 15 as carry into the upper part
    assign w_sum = (ACC_W+1)'(i_acc)
                 + (ACC_W+1)'($signed(r_prod[2*VAL_W-1:16]))
                 + (ACC_W+1)'(r_prod[15]);

    always_comb begin
        o_ovf = (w_sum[ACC_W] != w_sum[ACC_W-1]);
        if (!o_ovf) begin
            o_sum = w_sum[ACC_W-1:0];
        end else if (w_sum[ACC_W]) begin
            o_sum = ACC_MIN;
        end else begin
            o_sum = ACC_MAX;
        end
    end

endmodule

[rtl/csr_spmv_accumulate.sv]
// Sparse matrix (CSR nonzeros) times dense vector, accumulated per row in Q32.16 with
// saturation and a sticky per-row saturation flag. Requests: clear all rows, write a vector
// element, apply one nonzero, read one row. Steps per request, from acceptance: a vector
// write goes into the vector memory; an apply does a memory read, a 32x32 multiply, then
// an add/saturate and write back into the single accumulator memory; a read fetches the
// row and waits for the output register to drain; and a clear sweeps the accumulator
// memory one row per cycle. After reset the same clearing pass runs before the first
// request is taken. The block handles one request at a time, so reads and writes of the
// same accumulator row never overlap.
`include "csr_spmv_accumulate_defines.svh"

module csr_spmv_accumulate #(
    parameter int TILE_ROWS     = 1024,
    parameter int VECTOR_LENGTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [1:0]                              i_req_type,
    input  logic [csr_spmv_pkg::IDX_W-1:0]          i_row_index,
    input  logic [csr_spmv_pkg::IDX_W-1:0]          i_col_index,
    input  logic signed [csr_spmv_pkg::VAL_W-1:0]   i_value,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [csr_spmv_pkg::ACC_W-1:0]   o_row_sum,
    output logic [csr_spmv_pkg::IDX_W-1:0]          o_row_number,
    output logic                                    o_saturated
);

    import csr_spmv_pkg::*;

    localparam int RA_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
    localparam int VA_W = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
    localparam logic [RA_W-1:0] LAST_ROW = RA_W'(TILE_ROWS - 1);

    t_state r_state, n_state;
    logic [RA_W-1:0] r_clr_pos, n_clr_pos;

    logic [IDX_W-1:0]        r_row;
    logic signed [VAL_W-1:0] r_value;
    logic                    r_row_ok;
    logic                    r_col_ok;

    logic                    r_out_valid;
    logic signed [ACC_W-1:0] r_out_sum;
    logic [IDX_W-1:0]        r_out_row;
    logic                    r_out_sat;

    t_req        w_req;
    logic        w_accept;
    logic        w_out_free;
    logic [16:0] w_row_ext;
    logic [16:0] w_col_ext;
    logic [16:0] w_rrow_ext;
    logic        w_row_in_tile;
    logic        w_row_in_vec;
    logic        w_col_in_vec;

    logic                    w_vec_we;
    logic                    w_vec_re;
    logic [VAL_W-1:0]        w_vec_rdata;
    logic signed [VAL_W-1:0] w_vec;

    logic                    w_acc_we;
    logic [RA_W-1:0]         w_acc_waddr;
    logic [ACC_W:0]          w_acc_wdata;
    logic                    w_acc_re;
    logic [ACC_W:0]          w_acc_rdata;
    logic                    w_mul_en;
    logic signed [ACC_W-1:0] w_sum;
    logic                    w_ovf;

    assign w_req         = t_req'(i_req_type);
    assign w_accept      = i_valid & o_ready;
    assign w_out_free    = !r_out_valid || i_ready;
    assign w_row_ext     = 17'(i_row_index);
    assign w_col_ext     = 17'(i_col_index);
    assign w_rrow_ext    = 17'(r_row);
    assign w_row_in_tile = int'(i_row_index) < TILE_ROWS;
    assign w_row_in_vec  = int'(i_row_index) < VECTOR_LENGTH;
    assign w_col_in_vec  = int'(i_col_index) < VECTOR_LENGTH;

    // next state
    always_comb begin
        n_state   = r_state;
        n_clr_pos = r_clr_pos;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_req)
                        REQ_CLEAR: n_state = ST_CLEAR;
                        REQ_APPLY: n_state = ST_MUL;
                        REQ_READ:  n_state = ST_READ;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (r_clr_pos == LAST_ROW) begin
                    n_state   = ST_IDLE;
                    n_clr_pos = '0;
                end else begin
                    n_clr_pos = RA_W'(r_clr_pos + 1'b1);
                end
            end
            ST_MUL:  n_state = ST_ACC;
            ST_ACC:  n_state = ST_IDLE;
            ST_READ: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ready     = 1'b0;
        w_mul_en    = 1'b0;
        w_acc_we    = 1'b0;
        w_acc_waddr = w_rrow_ext[RA_W-1:0];
        w_acc_wdata = {w_acc_rdata[ACC_W] | w_ovf, w_sum};
        case (r_state)
            ST_IDLE:  o_ready = 1'b1;
            ST_CLEAR: begin
                w_acc_we    = 1'b1;
                w_acc_waddr = r_clr_pos;
                w_acc_wdata = '0;
            end
            ST_MUL:   w_mul_en = 1'b1;
            ST_ACC:   w_acc_we = r_row_ok;
            default:  o_ready = 1'b0;
        endcase
    end

    assign w_vec_we = w_accept && (w_req == REQ_WRITE) && w_row_in_vec;
    assign w_vec_re = w_accept && (w_req == REQ_APPLY);
    assign w_acc_re = w_accept && ((w_req == REQ_APPLY) || (w_req == REQ_READ));
    assign w_vec    = r_col_ok ? $signed(w_vec_rdata) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_pos <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_pos <= n_clr_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row    <= i_row_index;
            r_value  <= i_value;
            r_row_ok <= w_row_in_tile;
            r_col_ok <= w_col_in_vec;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_READ) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_READ) && w_out_free) begin
            r_out_row <= r_row;
            r_out_sum <= r_row_ok ? $signed(w_acc_rdata[ACC_W-1:0]) : '0;
            r_out_sat <= r_row_ok & w_acc_rdata[ACC_W];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_row_sum    = r_out_sum;
    assign o_row_number = r_out_row;
    assign o_saturated  = r_out_sat;

    csr_spmv_ram #(
        .DEPTH (VECTOR_LENGTH),
        .WIDTH (VAL_W)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (w_vec_we),
        .i_waddr (w_row_ext[VA_W-1:0]),
        .i_wdata (i_value),
        .i_re    (w_vec_re),
        .i_raddr (w_col_ext[VA_W-1:0]),
        .o_rdata (w_vec_rdata)
    );

    // accumulator word: saturation flag on top of the Q32.16 sum
    csr_spmv_ram #(
        .DEPTH (TILE_ROWS),
        .WIDTH (ACC_W + 1)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc_we),
        .i_waddr (w_acc_waddr),
        .i_wdata (w_acc_wdata),
        .i_re    (w_acc_re),
        .i_raddr (w_row_ext[RA_W-1:0]),
        .o_rdata (w_acc_rdata)
    );

    csr_spmv_mac u_mac (
        .i_clk    (i_clk),
        .i_mul_en (w_mul_en),
        .i_value  (r_value),
        .i_vec    (w_vec),
        .i_acc    ($signed(w_acc_rdata[ACC_W-1:0])),
        .o_sum    (w_sum),
        .o_ovf    (w_ovf)
    );

    `CSR_SPMV_ASSERT(a_read_seq, i_clk, i_rst_n, (w_accept && (w_req == REQ_READ)) |=> (r_state == ST_READ), "read request did not reach read state")
    `CSR_SPMV_ASSERT(a_out_src, i_clk, i_rst_n, $rose(o_valid) |-> ($past(r_state) == ST_READ), "result appeared without a read")
    `CSR_SPMV_ASSERT(a_no_wr_read, i_clk, i_rst_n, (r_state == ST_READ) |-> !w_acc_we, "accumulator written during read")
    `CSR_SPMV_ASSERT_NORST(a_rst_clear, i_clk, !i_rst_n |=> (r_state == ST_CLEAR) && (r_clr_pos == '0), "reset did not start clearing pass")

endmodule
